### rtl/trfp_pkg.sv
// ----------------------------------------------------------------------------
// trfp_pkg: shared types and constants for the tagged record field parser
// Item layout between front and back, phase and result codes, tag table.
// ----------------------------------------------------------------------------
package trfp_pkg;

  // Defaults for top-level parameters
  localparam int unsigned LABEL_LIMIT_DEF = 30;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CODE_W  = 5;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned LIMIT_W = 8;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TEXT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LIMIT = 1'b1;

  localparam logic [CFG_W-1:0] MAX_TEXT_RST     = 16'd4096;
  localparam logic [CFG_W-1:0] SEARCH_LIMIT_RST = 16'd10000;

  // Special bytes
  localparam logic [BYTE_W-1:0] START_MARKER = 8'hFF;
  localparam logic [BYTE_W-1:0] BODY_TAG     = "M";

  // Field codes
  localparam logic [CODE_W-1:0] CODE_ID   = 5'd0;
  localparam logic [CODE_W-1:0] CODE_BODY = 5'd28;

  // Known tags, in field-code order (code = index + 1)
  localparam int unsigned NUM_TAGS = 27;
  localparam logic [BYTE_W-1:0] TAG_CHARS [NUM_TAGS] = '{
    "A", "B", "C", "D", "F", "G", "I", "J", "j", "L", "N", "n", "O", "o",
    "P", "p", "Q", "q", "R", "S", "s", "T", "X", "Z", "z", ".", "_"
  };
  // Zero means the label limit applies
  localparam logic [LIMIT_W-1:0] TAG_LIMITS [NUM_TAGS] = '{
    8'd0, 8'd80, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd63, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd128, 8'd128, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd90, 8'd90
  };

  typedef enum logic [KIND_W-1:0] {
    KIND_ROOM,
    KIND_ATTR,
    KIND_CHAR,
    KIND_FIELD_END,
    KIND_SEARCH_FAIL,
    KIND_RECORD_END
  } kind_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ROOM,
    PH_ATTR,
    PH_FIELD,
    PH_TAG,
    PH_SKIP
  } phase_t;

  // Classified byte, as queued from front to back
  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic               is_zero;
    logic               is_marker;
    logic               is_body_tag;
    logic               known;
    logic [CODE_W-1:0]  code;
    logic [LIMIT_W-1:0] limit;
  } item_t;

endpackage

### rtl/trfp_front.sv
// ----------------------------------------------------------------------------
// trfp_front: byte classifier
// Flags special bytes and looks up tag code and string limit for each byte.
// ----------------------------------------------------------------------------
module trfp_front #(
  parameter int unsigned LABEL_LIMIT = trfp_pkg::LABEL_LIMIT_DEF
) (
  input  logic [trfp_pkg::BYTE_W-1:0] byte_in,
  output trfp_pkg::item_t             item
);

  logic                          hit;
  logic [trfp_pkg::CODE_W-1:0]   hit_code;
  logic [trfp_pkg::LIMIT_W-1:0]  hit_limit;

  // 27 independent compares; at most one can match
  always_comb begin
    hit       = 1'b0;
    hit_code  = trfp_pkg::CODE_ID;
    hit_limit = '0;
    for (int i = 0; i < trfp_pkg::NUM_TAGS; i++) begin
      if (byte_in == trfp_pkg::TAG_CHARS[i]) begin
        hit      = 1'b1;
        hit_code = trfp_pkg::CODE_W'(i + 1);
        hit_limit = (trfp_pkg::TAG_LIMITS[i] == '0) ?
                    trfp_pkg::LIMIT_W'(LABEL_LIMIT) : trfp_pkg::TAG_LIMITS[i];
      end
    end
  end

  always_comb begin
    item.data        = byte_in;
    item.is_zero     = (byte_in == '0);
    item.is_marker   = (byte_in == trfp_pkg::START_MARKER);
    item.is_body_tag = (byte_in == trfp_pkg::BODY_TAG);
    item.known       = hit;
    item.code        = hit_code;
    item.limit       = hit_limit;
  end

endmodule

### rtl/trfp_queue.sv
// ----------------------------------------------------------------------------
// trfp_queue: short item queue between front and back
// Register-array FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module trfp_queue #(
  parameter int unsigned DEPTH = trfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  trfp_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output trfp_pkg::item_t head_item
);

  localparam int unsigned PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  trfp_pkg::item_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count out of range");

endmodule

### rtl/trfp_back.sv
// ----------------------------------------------------------------------------
// trfp_back: record state machine and result register
// Walks hunt / room / attribute / field / tag / skip phases per queued item.
// ----------------------------------------------------------------------------
module trfp_back #(
  parameter int unsigned LABEL_LIMIT = trfp_pkg::LABEL_LIMIT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [trfp_pkg::CFG_W-1:0]   max_text,
  input  logic [trfp_pkg::CFG_W-1:0]   search_limit,
  input  logic                         head_valid,
  input  trfp_pkg::item_t              head_item,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [trfp_pkg::KIND_W-1:0]  kind,
  output logic [trfp_pkg::CODE_W-1:0]  field_code,
  output logic [trfp_pkg::BYTE_W-1:0]  value_out,
  output logic [trfp_pkg::POS_W-1:0]   position
);

  trfp_pkg::phase_t            phase, phase_next;
  logic [trfp_pkg::CFG_W-1:0]  search_count, search_count_next, count_inc;
  logic [trfp_pkg::CODE_W-1:0] current_field, current_field_next;
  logic [trfp_pkg::POS_W-1:0]  room_left, room_left_next;
  logic [trfp_pkg::POS_W-1:0]  char_index, char_index_next;

  logic                         emit;
  trfp_pkg::kind_t              res_kind;
  logic [trfp_pkg::CODE_W-1:0]  res_code;
  logic [trfp_pkg::BYTE_W-1:0]  res_value;
  logic [trfp_pkg::POS_W-1:0]   res_pos;

  // Pop whenever the result register is free or draining this cycle
  assign pop = head_valid && (!out_valid || !out_stall);

  // Saturating hunt counter
  assign count_inc = (search_count != '1) ? search_count + 16'd1 : search_count;

  always_comb begin
    phase_next         = phase;
    search_count_next  = search_count;
    current_field_next = current_field;
    room_left_next     = room_left;
    char_index_next    = char_index;
    emit      = 1'b0;
    res_kind  = trfp_pkg::KIND_CHAR;
    res_code  = current_field;
    res_value = '0;
    res_pos   = '0;
    case (phase)
      trfp_pkg::PH_ROOM: begin
        phase_next = trfp_pkg::PH_ATTR;
        emit       = 1'b1;
        res_kind   = trfp_pkg::KIND_ROOM;
        res_code   = trfp_pkg::CODE_ID;
        res_value  = head_item.data;
      end
      trfp_pkg::PH_ATTR: begin
        phase_next         = trfp_pkg::PH_FIELD;
        current_field_next = trfp_pkg::CODE_ID;
        room_left_next     = trfp_pkg::POS_W'(LABEL_LIMIT);
        char_index_next    = '0;
        emit      = 1'b1;
        res_kind  = trfp_pkg::KIND_ATTR;
        res_code  = trfp_pkg::CODE_ID;
        res_value = head_item.data;
      end
      trfp_pkg::PH_FIELD: begin
        if (head_item.is_zero) begin
          emit    = 1'b1;
          res_pos = char_index;
          if (current_field == trfp_pkg::CODE_BODY) begin
            phase_next        = trfp_pkg::PH_HUNT;
            search_count_next = '0;
            res_kind          = trfp_pkg::KIND_RECORD_END;
          end else begin
            phase_next = trfp_pkg::PH_TAG;
            res_kind   = trfp_pkg::KIND_FIELD_END;
          end
        end else if (room_left != '0) begin
          emit            = 1'b1;
          res_value       = head_item.data;
          res_pos         = char_index;
          room_left_next  = room_left - 16'd1;
          char_index_next = char_index + 16'd1;
        end
      end
      trfp_pkg::PH_TAG: begin
        if (head_item.is_body_tag) begin
          phase_next         = trfp_pkg::PH_FIELD;
          current_field_next = trfp_pkg::CODE_BODY;
          room_left_next     = max_text;
          char_index_next    = '0;
        end else if (head_item.known) begin
          phase_next         = trfp_pkg::PH_FIELD;
          current_field_next = head_item.code;
          room_left_next     = trfp_pkg::POS_W'(head_item.limit);
          char_index_next    = '0;
        end else begin
          phase_next = trfp_pkg::PH_SKIP;
        end
      end
      trfp_pkg::PH_SKIP: begin
        if (head_item.is_zero) begin
          phase_next = trfp_pkg::PH_TAG;
        end
      end
      default: begin
        // hunting; unused codes fall back here
        phase_next = trfp_pkg::PH_HUNT;
        if (head_item.is_marker) begin
          phase_next        = trfp_pkg::PH_ROOM;
          search_count_next = '0;
        end else if (count_inc >= search_limit) begin
          search_count_next = '0;
          emit              = 1'b1;
          res_kind          = trfp_pkg::KIND_SEARCH_FAIL;
          res_code          = trfp_pkg::CODE_ID;
        end else begin
          search_count_next = count_inc;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= trfp_pkg::PH_HUNT;
      search_count  <= '0;
      current_field <= trfp_pkg::CODE_ID;
      room_left     <= '0;
      char_index    <= '0;
    end else if (pop) begin
      phase         <= phase_next;
      search_count  <= search_count_next;
      current_field <= current_field_next;
      room_left     <= room_left_next;
      char_index    <= char_index_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      kind       <= res_kind;
      field_code <= res_code;
      value_out  <= res_value;
      position   <= res_pos;
    end
  end

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    (pop && emit) |=> out_valid)
    else $error("result lost after pop");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == trfp_pkg::KIND_SEARCH_FAIL) |->
      (field_code == trfp_pkg::CODE_ID && value_out == '0 && position == '0))
    else $error("search fail carries payload");

  a_record_end_body: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == trfp_pkg::KIND_RECORD_END) |->
      (field_code == trfp_pkg::CODE_BODY && value_out == '0))
    else $error("record end outside body");

endmodule

### rtl/tagged_record_field_parser_top.sv
// ----------------------------------------------------------------------------
// tagged_record_field_parser_top: tagged message record field parser
// Hunts for a start marker, then splits room, attribute, id, tagged header
// strings and body text into per-character and field-end items.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   in       | in_valid / in_stall       | byte_in
//   out      | out_valid / out_stall     | kind, field_code, value_out, position
//   cfg      | cfg_write (no handshake)  | cfg_index, cfg_data
//
// Sustained rate is one item per cycle: the back state machine retires one
// queued byte per clock, limited only by the result register draining.
// From input accept to result, the byte is first written into the queue, then
// the state update loads the result register.
// Synchronous reset clears queue pointers, parser phase and counters and the
// result valid; config registers return to max_text 4096, search_limit 10000.
// in_stall rises only when the queue is full; out_stall backs up the result
// register, then the queue, then the input.
// ----------------------------------------------------------------------------
module tagged_record_field_parser_top #(
  parameter int unsigned LABEL_LIMIT = trfp_pkg::LABEL_LIMIT_DEF,
  parameter int unsigned QUEUE_DEPTH = trfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input bytes
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [trfp_pkg::BYTE_W-1:0]    byte_in,
  // results
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [trfp_pkg::KIND_W-1:0]    kind,
  output logic [trfp_pkg::CODE_W-1:0]    field_code,
  output logic [trfp_pkg::BYTE_W-1:0]    value_out,
  output logic [trfp_pkg::POS_W-1:0]     position,
  // configuration writes
  input  logic                           cfg_write,
  input  logic [trfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trfp_pkg::CFG_W-1:0]     cfg_data
);

  logic [trfp_pkg::CFG_W-1:0] max_text;
  logic [trfp_pkg::CFG_W-1:0] search_limit;

  trfp_pkg::item_t front_item;
  trfp_pkg::item_t head_item;
  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            head_valid;

  // Config registers; the user must write them only while the parser is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      max_text     <= trfp_pkg::MAX_TEXT_RST;
      search_limit <= trfp_pkg::SEARCH_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        trfp_pkg::REG_MAX_TEXT:     max_text     <= cfg_data;
        trfp_pkg::REG_SEARCH_LIMIT: search_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input side: accept whenever the queue has room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Front: classify the byte as it arrives
  trfp_front #(
    .LABEL_LIMIT (LABEL_LIMIT)
  ) u_front (
    .byte_in (byte_in),
    .item    (front_item)
  );

  // Decoupling queue
  trfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Back: record state machine and result register
  trfp_back #(
    .LABEL_LIMIT (LABEL_LIMIT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .max_text     (max_text),
    .search_limit (search_limit),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .field_code   (field_code),
    .value_out    (value_out),
    .position     (position)
  );

endmodule

### tb/sv/tagged_record_field_parser_top_tb.sv
// ----------------------------------------------------------------------------
// tagged_record_field_parser_top_tb: self-checking bench for the record parser
// Feeds marker hunts, whole and truncated records and noise under random
// handshake gaps, predicts every result and compares them in order.
// ----------------------------------------------------------------------------

// Tracks parser state alongside the block and holds the results still owed.
class record_scoreboard;

  typedef struct packed {
    trfp_pkg::kind_t kind;
    logic [4:0]      code;
    logic [7:0]      value;
    logic [15:0]     pos;
  } field_event_t;

  // known tags in field-code order (code = index + 1)
  string tags = "ABCDFGIJjLNnOoPpQqRSsTXZz._";

  int unsigned label_limit;
  int unsigned errors;

  logic [15:0] max_text;
  logic [15:0] search_limit;

  trfp_pkg::phase_t phase;
  logic [15:0]      search_count;
  logic [4:0]       cur_field;
  logic [15:0]      room_left;
  logic [15:0]      char_index;

  field_event_t expected_events[$];

  function new(int unsigned lim);
    label_limit  = lim;
    errors       = 0;
    max_text     = 16'd4096;
    search_limit = 16'd10000;
    phase        = trfp_pkg::PH_HUNT;
    search_count = '0;
    cur_field    = '0;
    room_left    = '0;
    char_index   = '0;
  endfunction

  function logic [7:0] tag_char(int unsigned i);
    return tags[i];
  endfunction

  function int unsigned field_limit(logic [7:0] t);
    case (t)
      "B":      return 80;
      "L":      return 63;
      "P", "p": return 128;
      ".", "_": return 90;
      default:  return label_limit;
    endcase
  endfunction

  function void set_reg(logic [0:0] idx, logic [15:0] v);
    if (idx == trfp_pkg::REG_MAX_TEXT) max_text = v;
    else search_limit = v;
  endfunction

  function void open_string(logic [4:0] code, logic [15:0] lim);
    phase      = trfp_pkg::PH_FIELD;
    cur_field  = code;
    room_left  = lim;
    char_index = '0;
  endfunction

  // Advance the predicted parser by one accepted byte.
  function void parse_byte(logic [7:0] b);
    field_event_t ev;
    bit           owed;
    bit           found;
    ev   = '0;
    owed = 1'b0;
    case (phase)
      trfp_pkg::PH_ROOM: begin
        phase    = trfp_pkg::PH_ATTR;
        ev.kind  = trfp_pkg::KIND_ROOM;
        ev.value = b;
        owed     = 1'b1;
      end
      trfp_pkg::PH_ATTR: begin
        open_string(trfp_pkg::CODE_ID, 16'(label_limit));
        ev.kind  = trfp_pkg::KIND_ATTR;
        ev.value = b;
        owed     = 1'b1;
      end
      trfp_pkg::PH_FIELD: begin
        if (b == 8'h00) begin
          ev.code = cur_field;
          ev.pos  = char_index;
          if (cur_field == trfp_pkg::CODE_BODY) begin
            phase        = trfp_pkg::PH_HUNT;
            search_count = '0;
            ev.kind      = trfp_pkg::KIND_RECORD_END;
          end else begin
            phase   = trfp_pkg::PH_TAG;
            ev.kind = trfp_pkg::KIND_FIELD_END;
          end
          owed = 1'b1;
        end else if (room_left != 0) begin
          ev.kind    = trfp_pkg::KIND_CHAR;
          ev.code    = cur_field;
          ev.value   = b;
          ev.pos     = char_index;
          room_left  = room_left - 1'b1;
          char_index = char_index + 1'b1;
          owed       = 1'b1;
        end
      end
      trfp_pkg::PH_TAG: begin
        if (b == trfp_pkg::BODY_TAG) begin
          open_string(trfp_pkg::CODE_BODY, max_text);
        end else begin
          found = 1'b0;
          for (int i = 0; i < tags.len(); i++) begin
            if (tags[i] == b) begin
              found = 1'b1;
              open_string(5'(i + 1), 16'(field_limit(b)));
            end
          end
          if (!found) phase = trfp_pkg::PH_SKIP;
        end
      end
      trfp_pkg::PH_SKIP: begin
        if (b == 8'h00) phase = trfp_pkg::PH_TAG;
      end
      default: begin
        // hunting, and any stray phase code behaves the same
        phase = trfp_pkg::PH_HUNT;
        if (b == trfp_pkg::START_MARKER) begin
          phase        = trfp_pkg::PH_ROOM;
          search_count = '0;
        end else begin
          if (search_count != 16'hFFFF) search_count = search_count + 1'b1;
          if (search_count >= search_limit) begin
            search_count = '0;
            ev.kind      = trfp_pkg::KIND_SEARCH_FAIL;
            owed         = 1'b1;
          end
        end
      end
    endcase
    if (owed) expected_events.push_back(ev);
  endfunction

  task report(string what);
    errors++;
    if (errors <= 100) $display("ERROR: %s", what);
  endtask

  task check_event(logic [2:0] k, logic [4:0] c, logic [7:0] v, logic [15:0] p);
    field_event_t want;
    if (expected_events.size() == 0) begin
      report($sformatf("unexpected result kind %0d code %0d value %0d pos %0d", k, c, v, p));
      return;
    end
    want = expected_events.pop_front();
    if (k !== want.kind)
      report($sformatf("kind %0d, want %0d", k, want.kind));
    if (c !== want.code)
      report($sformatf("field_code %0d, want %0d (kind %0d)", c, want.code, want.kind));
    if (v !== want.value)
      report($sformatf("value_out %0d, want %0d (kind %0d)", v, want.value, want.kind));
    if (p !== want.pos)
      report($sformatf("position %0d, want %0d (kind %0d)", p, want.pos, want.kind));
  endtask

endclass

module tagged_record_field_parser_top_tb;
  import trfp_pkg::*;

  localparam int unsigned LABEL_LIMIT     = 30;
  localparam int unsigned SETTLE          = 16;     // queue depth + pipe, with margin
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned PHASES          = 5;
  localparam int unsigned ITEMS_PER_PHASE = 215;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    byte_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [KIND_W-1:0]    kind;
  logic [CODE_W-1:0]    field_code;
  logic [BYTE_W-1:0]    value_out;
  logic [POS_W-1:0]     position;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  tagged_record_field_parser_top #(
    .LABEL_LIMIT(LABEL_LIMIT)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_in    (byte_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .field_code (field_code),
    .value_out  (value_out),
    .position   (position),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  record_scoreboard book = new(LABEL_LIMIT);

  logic [7:0]  stream[$];      // bytes built but not yet sent
  int unsigned sent;           // bytes accepted in the current phase
  int unsigned next_tag = 0;   // round-robin over the known tags
  int unsigned cycles = 0;
  bit          send_calm = 1'b0;
  bit          sink_calm = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Wait before the next item; now and then flip into a calm stretch with no
  // gaps at all, so both back-to-back and ragged traffic show up.
  function automatic int unsigned draw_wait(ref bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // ---------------------------------------------------------------- driving

  // Called at a rising edge; returns at the edge where the byte went in.
  // in_valid only drops when a gap is drawn, so a held valid never toggles.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = draw_wait(send_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.parse_byte(b);
  endtask

  task automatic flush_stream;
    while (stream.size() != 0) begin
      send_byte(stream.pop_front());
      sent++;
    end
  endtask

  // Hold off input until every owed result is back, then let bytes that make
  // no result (tags, dropped chars) drain out of the queue.
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (book.expected_events.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Only used while idle. Trailing edge keeps cfg_write to one update a step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    book.set_reg(idx, v);
    @(posedge clk);
  endtask

  // ------------------------------------------------------------- stimulus

  // Mostly short strings; sometimes straddle the cut so truncation is hit.
  // Huge limits (body at 4096 and up) always get short strings.
  function automatic int unsigned pick_len(int unsigned limit);
    if (limit <= 130 && $urandom_range(0, 9) == 0)
      return $urandom_range(limit > 2 ? limit - 2 : 0, limit + 3);
    return $urandom_range(0, 6);
  endfunction

  function automatic void add_text(int unsigned len);
    repeat (len) stream.push_back(8'($urandom_range(1, 255)));
    stream.push_back(8'h00);
  endfunction

  // One well-formed record: optional lead-in noise, marker, room, attribute,
  // id, a few tagged strings (some unknown tags), body.
  function automatic void add_record;
    int unsigned ntags;
    logic [7:0]  tag;
    repeat ($urandom_range(0, 3)) stream.push_back(8'($urandom_range(0, 254)));
    stream.push_back(START_MARKER);
    stream.push_back(8'($urandom));
    stream.push_back(8'($urandom));
    add_text(pick_len(LABEL_LIMIT));
    ntags = $urandom_range(0, 4);
    repeat (ntags) begin
      if ($urandom_range(0, 4) == 0) begin
        tag = 8'($urandom);
        if (tag == BODY_TAG) tag = 8'h00;   // keep the header open
      end else begin
        tag      = book.tag_char(next_tag);
        next_tag = (next_tag + 1) % 27;
      end
      stream.push_back(tag);
      add_text(pick_len(book.field_limit(tag)));
    end
    stream.push_back(BODY_TAG);
    add_text(pick_len(book.max_text));
  endfunction

  // ----------------------------------------------------------- result side

  // Per result, hold stall for a drawn wait (possibly none), then release until
  // a result goes out.
  initial begin
    int unsigned w;
    @(posedge clk);
    forever begin
      w = draw_wait(sink_calm);
      if (w != 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      book.check_event(kind, field_code, value_out, position);
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tagged_record_field_parser_top: mismatch");
    $finish;
  end

  // ----------------------------------------------------------- main flow
  initial begin
    logic [15:0] mt;
    logic [15:0] sl;
    int unsigned r;
    int unsigned cut;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed, at reset settings: a full record touching every result kind
    // but search failure; id chars at the byte extremes, a zero byte in tag
    // position, an unknown letter tag, a body ending the record.
    stream = '{8'hFF, 8'h00, 8'hFF,             // marker, room, attribute
               8'h80, 8'h7F, 8'h00,             // id
               "B", "x", 8'h00,
               8'h00, "q", 8'h00,               // zero as tag: string skipped
               "K", 8'h00,                      // unknown tag, empty string
               "M", "h", "i", 8'h00};           // body, record end
    flush_stream();

    // Three non-marker bytes counted under the reset limit, then the limit
    // drops below the count: the next non-marker byte must fail the search.
    stream = '{8'h01, 8'h80, 8'h04};
    flush_stream();
    drain();
    write_reg(REG_SEARCH_LIMIT, 16'd2);
    stream = '{8'h7E};
    flush_stream();
    // Zero limit: every non-marker byte fails.
    drain();
    write_reg(REG_SEARCH_LIMIT, 16'd0);
    write_reg(REG_MAX_TEXT, 16'd2);
    stream = '{8'h00};
    flush_stream();
    // Empty id, body longer than max_text: third char dropped, length 2.
    stream = '{8'hFF, 8'h00, 8'h00, 8'h00, "M", "a", "b", "c", 8'h00};
    flush_stream();

    // Random phases, each under its own settings, extremes first.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin mt = 16'd0;     sl = 16'd1;     end
        1:       begin mt = 16'hFFFF;  sl = 16'hFFFF;  end
        2:       begin mt = 16'd3;     sl = 16'd4;     end
        default: begin
          mt = 16'($urandom_range(0, 40));
          sl = 16'($urandom_range(1, 12));
        end
      endcase
      drain();
      write_reg(REG_MAX_TEXT, mt);
      write_reg(REG_SEARCH_LIMIT, sl);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 78) begin
          add_record();
        end else if (r < 90) begin
          // truncated record: parser may be left mid-record for the next one
          add_record();
          cut = $urandom_range(1, stream.size() - 1);
          repeat (cut) void'(stream.pop_back());
        end else begin
          repeat ($urandom_range(1, 30)) stream.push_back(8'($urandom));
        end
        flush_stream();
      end
    end

    in_valid <= 1'b0;
    while (book.expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (book.errors == 0 && book.expected_events.size() == 0) begin
      $display("tagged_record_field_parser_top: match");
    end else begin
      $display("tagged_record_field_parser_top: mismatch");
    end
    $finish;
  end

endmodule

### files.f
rtl/trfp_pkg.sv
rtl/trfp_front.sv
rtl/trfp_queue.sv
rtl/trfp_back.sv
rtl/tagged_record_field_parser_top.sv
tb/sv/tagged_record_field_parser_top_tb.sv
